// File: rtl/core/lzeul_pkg.sv
// Shared widths, reset values and register codes of the Lorenz Euler integrator.
`default_nettype none

package lzeul_pkg;

  localparam int Q_W       = 32;
  localparam int Q_FRAC    = 24;
  localparam int DT_W      = 31;
  localparam int CNT_W     = 16;
  localparam int CFG_IDX_W = 3;
  localparam int PROD_W    = 2 * Q_W;

  localparam logic signed [Q_W-1:0] Q_MAX = {1'b0, {(Q_W-1){1'b1}}};
  localparam logic signed [Q_W-1:0] Q_MIN = {1'b1, {(Q_W-1){1'b0}}};

  // Rounding constant: one half of the last Q8.24 bit in the double-width product.
  localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(64'sd1 <<< (Q_FRAC - 1));

  localparam logic signed [Q_W-1:0] SIGMA_RST = 32'sd201326592;
  localparam logic signed [Q_W-1:0] BETA_RST  = 32'sd44738124;
  localparam logic signed [Q_W-1:0] RHO_RST   = 32'sd469762048;
  localparam logic [DT_W-1:0]       DT_RST    = 31'd167772;
  localparam logic signed [Q_W-1:0] ONE_Q     = 32'sd16777216;
  localparam logic [CNT_W-1:0]      MAX_RST   = 16'd2501;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SIGMA     = 3'd0,
    CFG_BETA      = 3'd1,
    CFG_RHO       = 3'd2,
    CFG_STEP_SIZE = 3'd3,
    CFG_START_X   = 3'd4,
    CFG_START_Y   = 3'd5,
    CFG_START_Z   = 3'd6,
    CFG_MAX_STEPS = 3'd7
  } cfg_reg_t;

endpackage

`default_nettype wire

// File: rtl/core/lorenz_euler_step.sv
// Top level of the Lorenz system integrator: forward Euler in signed Q8.24.
//
// Each input transaction carries one bit, in_restart. A restart transaction
// reloads the start point from the configuration registers and clears the
// step count; any other transaction takes one Euler step from the current
// point, unless the step count has already reached max_steps, in which case
// the point holds and finished is reported. Every input transaction yields
// exactly one output transaction with the point, the count and two flags.
// The configuration port is always ready; registers should be written only
// while no transaction is in flight. A new start point applies at the next
// restart, the other registers at the next step.
// A restart or a held step goes from accept straight to loading the output
// register. A real step first takes the two differences, then passes each of
// the seven products, one at a time, through a single 32 by 32 multiplier,
// a rounding stage and a saturating adder, and then loads the output
// register. The block then returns to idle, and only then is the next
// input transaction accepted.
// in_stall is high from accept until the result sits in the output register.
// When the receiver stalls, the result is held in the output register and a
// new input transaction may still be accepted; its result waits until the
// register is free. Synchronous reset restores the register defaults, the
// point (1, 1, 1) and a zero count, and drops out_valid.
`default_nettype none

module lorenz_euler_step
  import lzeul_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // Input channel
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic                  in_restart,
  // Result channel
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic signed [Q_W-1:0]      out_x_pos,
  output logic signed [Q_W-1:0]      out_y_pos,
  output logic signed [Q_W-1:0]      out_z_pos,
  output logic [CNT_W-1:0]           out_step_count,
  output logic                       out_finished,
  output logic                       out_saturated,
  // Configuration write channel
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [Q_W-1:0]        cfg_data
);

  // Sequencer: the two differences, then MUL, RND and ACC once per product.
  typedef enum logic [2:0] {
    S_IDLE,
    S_DIFF_YX,
    S_DIFF_RZ,
    S_MUL,
    S_RND,
    S_ACC,
    S_DONE
  } state_t;

  // The seven products of one step, in the order they are issued.
  typedef enum logic [2:0] {
    OP_DX = 3'd0,   // sigma * (y - x)
    OP_DY = 3'd1,   // x * (rho - z), then minus y
    OP_XY = 3'd2,   // x * y
    OP_BZ = 3'd3,   // beta * z, subtracted from x * y
    OP_NX = 3'd4,   // dt * dx added to x
    OP_NY = 3'd5,   // dt * dy added to y
    OP_NZ = 3'd6    // dt * dz added to z
  } op_t;

  state_t                  state_r;
  op_t                     op_r;

  // Configuration registers.
  logic signed [Q_W-1:0]   sigma_r, beta_r, rho_r;
  logic [DT_W-1:0]         step_size_r;
  logic signed [Q_W-1:0]   start_x_r, start_y_r, start_z_r;
  logic [CNT_W-1:0]        max_steps_r;

  // Trajectory state.
  logic signed [Q_W-1:0]   x_r, y_r, z_r;
  logic [CNT_W-1:0]        count_r;

  // Intermediate values of one step.
  logic signed [Q_W-1:0]   dxy_r, drz_r, dx_r, dy_r, dz_r, xy_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [Q_W-1:0]   q_r;
  logic                    clip_r;

  // Output register.
  logic                    out_valid_r;
  logic signed [Q_W-1:0]   out_x_r, out_y_r, out_z_r;
  logic [CNT_W-1:0]        out_count_r;
  logic                    out_fin_r, out_sat_r;

  // Shared multiplier operands.
  logic signed [Q_W-1:0]   mul_a, mul_b;
  logic signed [Q_W-1:0]   dt_q;

  // Rounding stage.
  logic signed [PROD_W-1:0] rnd_full;
  logic                    rnd_ovf;
  logic signed [Q_W-1:0]   rnd_sat;

  // Shared saturating adder.
  logic signed [Q_W-1:0]   add_a, add_b;
  logic                    add_sub;
  logic signed [Q_W+1:0]   add_sum;
  logic                    add_ovf;
  logic signed [Q_W-1:0]   add_res;

  logic                    in_accept;
  logic                    out_free;

  assign in_stall  = (state_r != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign cfg_ready = 1'b1;

  assign dt_q = $signed({1'b0, step_size_r});

  always_comb begin
    mul_a = sigma_r;
    mul_b = dxy_r;
    case (op_r)
      OP_DX: begin mul_a = sigma_r; mul_b = dxy_r; end
      OP_DY: begin mul_a = x_r;     mul_b = drz_r; end
      OP_XY: begin mul_a = x_r;     mul_b = y_r;   end
      OP_BZ: begin mul_a = beta_r;  mul_b = z_r;   end
      OP_NX: begin mul_a = dt_q;    mul_b = dx_r;  end
      OP_NY: begin mul_a = dt_q;    mul_b = dy_r;  end
      OP_NZ: begin mul_a = dt_q;    mul_b = dz_r;  end
      default: begin mul_a = sigma_r; mul_b = dxy_r; end
    endcase
  end

  // Round half up, then clip to the Q8.24 range.
  always_comb begin
    rnd_full = (prod_r + ROUND_HALF) >>> Q_FRAC;
    rnd_ovf  = !((&rnd_full[PROD_W-1:Q_W-1]) || !(|rnd_full[PROD_W-1:Q_W-1]));
    if (rnd_ovf) begin
      rnd_sat = rnd_full[PROD_W-1] ? Q_MIN : Q_MAX;
    end else begin
      rnd_sat = rnd_full[Q_W-1:0];
    end
  end

  always_comb begin
    add_a   = q_r;
    add_b   = '0;
    add_sub = 1'b0;
    case (state_r)
      S_DIFF_YX: begin add_a = y_r;   add_b = x_r; add_sub = 1'b1; end
      S_DIFF_RZ: begin add_a = rho_r; add_b = z_r; add_sub = 1'b1; end
      S_ACC: begin
        case (op_r)
          OP_DX: begin add_a = q_r;  add_b = '0;  add_sub = 1'b0; end
          OP_DY: begin add_a = q_r;  add_b = y_r; add_sub = 1'b1; end
          OP_XY: begin add_a = q_r;  add_b = '0;  add_sub = 1'b0; end
          OP_BZ: begin add_a = xy_r; add_b = q_r; add_sub = 1'b1; end
          OP_NX: begin add_a = x_r;  add_b = q_r; add_sub = 1'b0; end
          OP_NY: begin add_a = y_r;  add_b = q_r; add_sub = 1'b0; end
          OP_NZ: begin add_a = z_r;  add_b = q_r; add_sub = 1'b0; end
          default: begin add_a = q_r; add_b = '0; add_sub = 1'b0; end
        endcase
      end
      default: begin add_a = q_r; add_b = '0; add_sub = 1'b0; end
    endcase
    if (add_sub) begin
      add_sum = {{2{add_a[Q_W-1]}}, add_a} - {{2{add_b[Q_W-1]}}, add_b};
    end else begin
      add_sum = {{2{add_a[Q_W-1]}}, add_a} + {{2{add_b[Q_W-1]}}, add_b};
    end
    add_ovf = !((&add_sum[Q_W+1:Q_W-1]) || !(|add_sum[Q_W+1:Q_W-1]));
    if (add_ovf) begin
      add_res = add_sum[Q_W+1] ? Q_MIN : Q_MAX;
    end else begin
      add_res = add_sum[Q_W-1:0];
    end
  end

  // Payload registers of the datapath.
  always_ff @(posedge clk) begin
    if (state_r == S_MUL) begin
      prod_r <= mul_a * mul_b;
    end
    if (state_r == S_RND) begin
      q_r <= rnd_sat;
    end
    if (state_r == S_DIFF_YX) begin
      dxy_r <= add_res;
    end
    if (state_r == S_DIFF_RZ) begin
      drz_r <= add_res;
    end
    if (state_r == S_ACC) begin
      case (op_r)
        OP_DX:   dx_r <= add_res;
        OP_DY:   dy_r <= add_res;
        OP_XY:   xy_r <= add_res;
        OP_BZ:   dz_r <= add_res;
        default: ;
      endcase
    end
  end

  // Sequencer, architectural state, configuration and output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      op_r        <= OP_DX;
      sigma_r     <= SIGMA_RST;
      beta_r      <= BETA_RST;
      rho_r       <= RHO_RST;
      step_size_r <= DT_RST;
      start_x_r   <= ONE_Q;
      start_y_r   <= ONE_Q;
      start_z_r   <= ONE_Q;
      max_steps_r <= MAX_RST;
      x_r         <= ONE_Q;
      y_r         <= ONE_Q;
      z_r         <= ONE_Q;
      count_r     <= '0;
      clip_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_reg_t'(cfg_index))
          CFG_SIGMA:     sigma_r     <= cfg_data;
          CFG_BETA:      beta_r      <= cfg_data;
          CFG_RHO:       rho_r       <= cfg_data;
          CFG_STEP_SIZE: step_size_r <= cfg_data[DT_W-1:0];
          CFG_START_X:   start_x_r   <= cfg_data;
          CFG_START_Y:   start_y_r   <= cfg_data;
          CFG_START_Z:   start_z_r   <= cfg_data;
          CFG_MAX_STEPS: max_steps_r <= cfg_data[CNT_W-1:0];
          default:       ;
        endcase
      end

      // A result taken by the receiver frees the register, unless a new one
      // is loaded in the same cycle below.
      if (out_valid_r && !out_stall && (state_r != S_DONE)) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        S_IDLE: begin
          if (in_accept) begin
            clip_r <= 1'b0;
            op_r   <= OP_DX;
            if (in_restart) begin
              x_r     <= start_x_r;
              y_r     <= start_y_r;
              z_r     <= start_z_r;
              count_r <= '0;
              state_r <= S_DONE;
            end else if (count_r < max_steps_r) begin
              state_r <= S_DIFF_YX;
            end else begin
              state_r <= S_DONE;
            end
          end
        end
        S_DIFF_YX: begin
          clip_r  <= clip_r | add_ovf;
          state_r <= S_DIFF_RZ;
        end
        S_DIFF_RZ: begin
          clip_r  <= clip_r | add_ovf;
          state_r <= S_MUL;
        end
        S_MUL: begin
          state_r <= S_RND;
        end
        S_RND: begin
          clip_r  <= clip_r | rnd_ovf;
          state_r <= S_ACC;
        end
        S_ACC: begin
          clip_r <= clip_r | add_ovf;
          case (op_r)
            OP_NX:   x_r <= add_res;
            OP_NY:   y_r <= add_res;
            OP_NZ:   z_r <= add_res;
            default: ;
          endcase
          if (op_r == OP_NZ) begin
            count_r <= count_r + 1'b1;
            state_r <= S_DONE;
          end else begin
            op_r    <= op_t'(op_r + 1'b1);
            state_r <= S_MUL;
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_x_r     <= x_r;
            out_y_r     <= y_r;
            out_z_r     <= z_r;
            out_count_r <= count_r;
            out_fin_r   <= (count_r >= max_steps_r);
            out_sat_r   <= clip_r;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid      = out_valid_r;
  assign out_x_pos      = out_x_r;
  assign out_y_pos      = out_y_r;
  assign out_z_pos      = out_z_r;
  assign out_step_count = out_count_r;
  assign out_finished   = out_fin_r;
  assign out_saturated  = out_sat_r;

endmodule

`default_nettype wire

// File: rtl/core/lzeul_checker.sv
// Port-level checks of the Lorenz Euler integrator, bound to its top level.
`default_nettype none

module lzeul_checker
  import lzeul_pkg::*;
(
  input wire logic                  clk,
  input wire logic                  rst_n,
  input wire logic                  in_valid,
  input wire logic                  in_stall,
  input wire logic                  out_valid,
  input wire logic                  out_stall,
  input wire logic signed [Q_W-1:0] out_x_pos,
  input wire logic [CNT_W-1:0]      out_step_count,
  input wire logic                  out_finished,
  input wire logic                  out_saturated
);

  // One transaction at a time: the input side closes right after an accept.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input accepted on two consecutive cycles");

  // A result only appears at the end of work, while the input side is closed.
  a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared without a transaction in flight");

  // A zero count only follows a restart or a held start point: never clipped.
  a_zero_count_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_step_count == '0)) |-> !out_saturated)
    else $error("zero step count reported with saturation");

  // A stalled result is held.
  a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_x_pos)
      && $stable(out_step_count) && $stable(out_finished)))
    else $error("stalled result changed or dropped");

endmodule

bind lorenz_euler_step lzeul_checker u_lzeul_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_x_pos      (out_x_pos),
  .out_step_count (out_step_count),
  .out_finished   (out_finished),
  .out_saturated  (out_saturated)
);

`default_nettype wire

// File: tb/lorenz_euler_step_tb.sv
// Self-checking testbench for the Lorenz forward Euler integrator with randomised flow control.
module lorenz_euler_step_tb;
  import lzeul_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // A quiet stretch after the last result makes sure that the block is
  // truly idle before a register write.
  localparam int SETTLE_CYCLES  = 30;
  // Well above the longest legitimate stretch without any transaction:
  // a step, a long sender gap and a long receiver stall together.
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int RANDOM_ITEMS   = 1100;

  // Kinds of random register setting used by the random phases.
  typedef enum int {
    KIND_PLAIN,      // Lorenz-like coefficients, small dt, modest start point
    KIND_FAR_START,  // Lorenz-like coefficients, start anywhere in Q8.24
    KIND_WIDE        // every register drawn over its whole range
  } setting_kind_t;

  // One result transaction as the block should present it.
  typedef struct packed {
    logic [Q_W-1:0]   x;
    logic [Q_W-1:0]   y;
    logic [Q_W-1:0]   z;
    logic [CNT_W-1:0] count;
    logic             finished;
    logic             saturated;
  } lorenz_result_t;

  // Clock, reset and the ports of the block. All inputs start at known values.
  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic                 in_restart = 1'b0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic signed [Q_W-1:0] out_x_pos;
  logic signed [Q_W-1:0] out_y_pos;
  logic signed [Q_W-1:0] out_z_pos;
  logic [CNT_W-1:0]     out_step_count;
  logic                 out_finished;
  logic                 out_saturated;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [Q_W-1:0]       cfg_data = '0;

  // Our own copy of the integrator: registers and trajectory state.
  logic signed [Q_W-1:0] m_sigma     = SIGMA_RST;
  logic signed [Q_W-1:0] m_beta      = BETA_RST;
  logic signed [Q_W-1:0] m_rho       = RHO_RST;
  logic [DT_W-1:0]       m_dt        = DT_RST;
  logic signed [Q_W-1:0] m_start_x   = ONE_Q;
  logic signed [Q_W-1:0] m_start_y   = ONE_Q;
  logic signed [Q_W-1:0] m_start_z   = ONE_Q;
  logic [CNT_W-1:0]      m_max_steps = MAX_RST;
  logic signed [Q_W-1:0] px = ONE_Q;
  logic signed [Q_W-1:0] py = ONE_Q;
  logic signed [Q_W-1:0] pz = ONE_Q;
  logic [CNT_W-1:0]      steps_done = '0;
  bit                    clipped;

  // Restart bits waiting to be driven, and the results the block owes us.
  bit             restart_queue[$];
  lorenz_result_t predicted_states[$];

  int  items_queued   = 0;
  int  items_accepted = 0;
  int  n_restarts     = 0;
  int  n_results      = 0;
  int  n_finished     = 0;
  int  n_saturated    = 0;
  int  n_settings     = 0;
  int  n_errors       = 0;
  int  quiet_cycles   = 0;
  int  in_gap         = 0;
  int  out_gap        = 0;
  bit  in_idle_on     = 1'b1;
  bit  out_idle_on    = 1'b1;

  lorenz_euler_step dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_restart     (in_restart),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_x_pos      (out_x_pos),
    .out_y_pos      (out_y_pos),
    .out_z_pos      (out_z_pos),
    .out_step_count (out_step_count),
    .out_finished   (out_finished),
    .out_saturated  (out_saturated),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always #6 clk = ~clk;

  // Clip to the signed 32-bit range, remembering that a clip happened.
  function automatic logic signed [63:0] clip32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) begin
      clipped = 1'b1;
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      clipped = 1'b1;
      return -64'sd2147483648;
    end
    return v;
  endfunction

  // Q8.24 product: exact product, add one half LSB, then floor shift by 24.
  // Both operands fit in 32 bits, so the 64-bit product never wraps.
  function automatic logic signed [63:0] qmul(input logic signed [63:0] a, b);
    logic signed [63:0] p;
    p = a * b + 64'sd8388608;
    return clip32(p >>> Q_FRAC);
  endfunction

  // Apply one input transaction to our copy of the integrator and return
  // the result transaction it must produce.
  function automatic lorenz_result_t advance_lorenz(input logic restart);
    lorenz_result_t     r;
    logic signed [63:0] x, y, z, h, dx, dy, dz;
    clipped = 1'b0;
    if (restart) begin
      px = m_start_x;
      py = m_start_y;
      pz = m_start_z;
      steps_done = '0;
    end else if (steps_done < m_max_steps) begin
      // All three derivatives are taken from the old point.
      x  = px;
      y  = py;
      z  = pz;
      h  = {{(64-DT_W){1'b0}}, m_dt};
      dx = qmul(m_sigma, clip32(y - x));
      dy = clip32(qmul(x, clip32(m_rho - z)) - y);
      dz = clip32(qmul(x, y) - qmul(m_beta, z));
      px = 32'(clip32(x + qmul(h, dx)));
      py = 32'(clip32(y + qmul(h, dy)));
      pz = 32'(clip32(z + qmul(h, dz)));
      steps_done = steps_done + 1'b1;
    end
    // Past the step limit the point and the count simply hold.
    r.x         = px;
    r.y         = py;
    r.z         = pz;
    r.count     = steps_done;
    r.finished  = (steps_done >= m_max_steps);
    r.saturated = clipped;
    return r;
  endfunction

  // Mostly short gaps, now and then a long one.
  function automatic int draw_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // A Q8.24 value with integer part in [lo, hi] and a random fraction.
  function automatic logic [Q_W-1:0] rand_q(input int lo, hi);
    int ip;
    ip = lo + int'($urandom_range(0, hi - lo));
    return {ip[7:0], 24'($urandom)};
  endfunction

  // A 32-bit word with the corner values drawn often.
  function automatic logic [Q_W-1:0] rand_wide();
    case ($urandom_range(0, 7))
      0:       return Q_MIN;
      1:       return Q_MAX;
      2:       return '0;
      3:       return '1;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [Q_W-1:0] draw_reg_value(input cfg_reg_t r,
                                                    input setting_kind_t kind);
    logic wide;
    int   pick;
    wide = (kind == KIND_WIDE);
    pick = $urandom_range(0, 9);
    case (r)
      CFG_SIGMA:     return wide ? rand_wide() : rand_q(4, 16);
      CFG_BETA:      return wide ? rand_wide() : rand_q(0, 3);
      CFG_RHO:       return wide ? rand_wide() : rand_q(10, 40);
      CFG_STEP_SIZE: return wide ? rand_wide() : 32'($urandom_range(0, 335544));
      CFG_START_X, CFG_START_Y, CFG_START_Z:
        return (kind == KIND_PLAIN) ? rand_q(-20, 20) : rand_wide();
      default: begin
        // The upper half of the word is junk the block must ignore.
        if (pick < 6) return {16'($urandom), 16'($urandom_range(0, 60))};
        if (pick == 6) return {16'($urandom), 16'd0};
        if (pick == 7) return {16'($urandom), 16'hFFFF};
        return $urandom;
      end
    endcase
  endfunction

  // Write one register; call at a rising edge. cfg_valid is left high so
  // that back-to-back writes need no second assignment in the same step.
  task automatic write_reg(input cfg_reg_t idx, input logic [Q_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_SIGMA:     m_sigma     = data;
      CFG_BETA:      m_beta      = data;
      CFG_RHO:       m_rho       = data;
      CFG_STEP_SIZE: m_dt        = data[DT_W-1:0];
      CFG_START_X:   m_start_x   = data;
      CFG_START_Y:   m_start_y   = data;
      CFG_START_Z:   m_start_z   = data;
      CFG_MAX_STEPS: m_max_steps = data[CNT_W-1:0];
      default:       ;
    endcase
  endtask

  task automatic queue_item(input bit restart);
    restart_queue.push_back(restart);
    items_queued++;
  endtask

  // A directed run of transactions: '1' is a restart, '0' a step.
  task automatic queue_items(input string pattern);
    for (int i = 0; i < pattern.len(); i++) queue_item(pattern[i] == "1");
  endtask

  // Wait until every queued transaction has been taken and answered, then
  // let the block settle so that the registers may be written safely.
  task automatic drain();
    while (items_accepted < items_queued || predicted_states.size() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic compare_field(input string name, input logic signed [63:0] want, got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      n_errors++;
    end
  endtask

  // Input driver. A transaction is taken at an edge with valid high and
  // stall low; that is when the prediction is made. The payload only moves
  // on once the slot is free, and a random gap may follow each transaction.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        predicted_states.push_back(advance_lorenz(in_restart));
        items_accepted++;
        if (in_restart) n_restarts++;
      end
      if (!in_valid || !in_stall) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (restart_queue.size() > 0) begin
          in_restart <= restart_queue.pop_front();
          in_valid   <= 1'b1;
          in_gap = in_idle_on ? draw_gap() : 0;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor. Each accepted result transaction is checked against
  // the oldest prediction; the receiver stalls for random stretches while out_idle_on is set.
  always @(posedge clk) begin
    lorenz_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      n_results++;
      if (predicted_states.size() == 0) begin
        $error("result transaction arrived with no prediction pending");
        n_errors++;
      end else begin
        want = predicted_states.pop_front();
        if (want.finished) n_finished++;
        if (want.saturated) n_saturated++;
        compare_field("x_pos", $signed(want.x), out_x_pos);
        compare_field("y_pos", $signed(want.y), out_y_pos);
        compare_field("z_pos", $signed(want.z), out_z_pos);
        compare_field("step_count", want.count, out_step_count);
        compare_field("finished", want.finished, out_finished);
        compare_field("saturated", want.saturated, out_saturated);
      end
    end
    if (out_gap > 0) begin
      out_gap--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
      if (out_idle_on) out_gap = draw_gap();
    end
  end

  // Watchdog: give up if no transaction of any kind happens for too long.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    int            len;
    int            random_items;
    setting_kind_t kind;
    random_items = 0;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Register defaults straight out of reset: a few steps, a restart and
    // one more step from the default start point.
    queue_items("00010");
    drain();

    // A new start point must not apply until the next restart. With a step
    // limit of two the trajectory then reaches the limit and holds; the
    // extreme start makes the first difference clip.
    write_reg(CFG_MAX_STEPS, 32'd2);
    write_reg(CFG_START_X, Q_MIN);
    write_reg(CFG_START_Y, Q_MAX);
    write_reg(CFG_START_Z, 32'd0);
    cfg_valid <= 1'b0;
    queue_items("01000");
    drain();

    // Extreme coefficients and a step limit of zero: the restart itself
    // already reports finished, and a step just holds.
    write_reg(CFG_SIGMA, Q_MAX);
    write_reg(CFG_BETA, Q_MIN);
    write_reg(CFG_RHO, Q_MIN);
    write_reg(CFG_STEP_SIZE, 32'h7FFF_FFFF);
    write_reg(CFG_MAX_STEPS, 32'd0);
    cfg_valid <= 1'b0;
    queue_items("10");
    drain();

    // Largest step limit with the same extreme coefficients, so the steps
    // saturate heavily.
    write_reg(CFG_MAX_STEPS, 32'h0000_FFFF);
    write_reg(CFG_START_X, 32'hFFFF_FFFF);
    write_reg(CFG_START_Y, 32'h0000_0001);
    write_reg(CFG_START_Z, Q_MAX);
    cfg_valid <= 1'b0;
    queue_items("1000");
    drain();

    // All coefficients zero and a zero time step: the point must not move,
    // and after a single step the limit of one is reached.
    write_reg(CFG_SIGMA, 32'd0);
    write_reg(CFG_BETA, 32'd0);
    write_reg(CFG_RHO, 32'd0);
    write_reg(CFG_STEP_SIZE, 32'd0);
    write_reg(CFG_MAX_STEPS, 32'd1);
    write_reg(CFG_START_X, 32'd0);
    cfg_valid <= 1'b0;
    queue_items("100");
    drain();
    n_settings = 5;

    // Random phases: a fresh register setting, then mostly a restart
    // followed by a run of steps, with the odd restart mixed in. Some
    // phases keep flow control quiet on one side or both.
    while (random_items < RANDOM_ITEMS) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: kind = KIND_PLAIN;
        6, 7:             kind = KIND_FAR_START;
        default:          kind = KIND_WIDE;
      endcase
      for (int i = 0; i < 8; i++)
        if ($urandom_range(0, 4) != 0)
          write_reg(cfg_reg_t'(i), draw_reg_value(cfg_reg_t'(i), kind));
      cfg_valid <= 1'b0;
      in_idle_on  = ($urandom_range(0, 3) != 0);
      out_idle_on = ($urandom_range(0, 3) != 0);
      len = $urandom_range(15, 70);
      for (int k = 0; k < len; k++)
        queue_item(k == 0 ? ($urandom_range(0, 9) < 8) : ($urandom_range(0, 24) == 0));
      random_items += len;
      n_settings++;
      drain();
    end

    if (predicted_states.size() != 0) begin
      $error("%0d predicted result transactions never arrived", predicted_states.size());
      n_errors++;
    end

    $display("Run covered %0d input transactions (%0d restarts) over %0d register settings.",
             items_accepted, n_restarts, n_settings);
    $display("Results checked: %0d, of which %0d finished and %0d saturated; %0d errors.",
             n_results, n_finished, n_saturated, n_errors);
    if (n_errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
